>>> hdl/agd_pkg.sv
// Shared types, constants and fixed-point helpers of the gradient divergence block.
`default_nettype none

package agd_pkg;

    localparam int MAX_COLUMNS     = 4096;
    localparam int COL_BITS        = $clog2(MAX_COLUMNS);
    localparam int CFG_COLS_BITS   = COL_BITS + 1;
    localparam int ROW_BITS        = 16;
    localparam int CFG_DATA_BITS   = (ROW_BITS > CFG_COLS_BITS) ? ROW_BITS : CFG_COLS_BITS;
    localparam int LUMA_BITS       = 16;
    localparam int ATTEN_BITS      = 16;
    localparam int ATTEN_FRAC_BITS = 12;
    localparam int DIV_BITS        = 24;
    localparam int DIFF_BITS       = LUMA_BITS + 1;
    localparam int PROD_BITS       = ATTEN_BITS + 1 + DIFF_BITS;
    localparam int SUM_BITS        = DIV_BITS + 2;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [ROW_BITS-1:0]      MIN_ROWS = ROW_BITS'(2);
    localparam logic [CFG_COLS_BITS-1:0] MIN_COLS = CFG_COLS_BITS'(2);
    localparam logic [CFG_COLS_BITS-1:0] MAX_COLS = CFG_COLS_BITS'(MAX_COLUMNS);

    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(1) << (ATTEN_FRAC_BITS - 1);
    localparam logic signed [PROD_BITS-1:0] TERM_MAX =
        (PROD_BITS'(1) << (DIV_BITS - 1)) - PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] TERM_MIN = ~TERM_MAX;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX =
        (SUM_BITS'(1) << (DIV_BITS - 1)) - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;

    typedef enum logic [0:0] {
        REG_IMAGE_ROWS    = 1'b0,
        REG_IMAGE_COLUMNS = 1'b1
    } cfg_reg_t;

    // Which terms of the divergence apply and which results an item causes.
    typedef struct packed {
        logic sub_left;
        logic sub_above;
        logic last_left;
        logic sub_lrh;
        logic last_col;
    } flags_t;

    // One classified pixel handed from the front to the back.
    typedef struct packed {
        logic signed [DIFF_BITS-1:0] diff_right;
        logic signed [DIFF_BITS-1:0] diff_below;
        logic signed [DIFF_BITS-1:0] diff_left;
        logic [ATTEN_BITS-1:0]       up_atten;
        logic [ATTEN_BITS-1:0]       left_atten;
        logic [COL_BITS-1:0]         col;
        flags_t                      flags;
    } work_t;

    // atten * diff, rounded to Q.10 (ties up) and saturated to the output width.
    function automatic logic signed [DIV_BITS-1:0] scaled_term(
        input logic [ATTEN_BITS-1:0]       atten,
        input logic signed [DIFF_BITS-1:0] diff
    );
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] rounded;
        logic signed [DIV_BITS-1:0]  result;
        prod    = $signed({1'b0, atten}) * diff;
        rounded = (prod + ROUND_HALF) >>> ATTEN_FRAC_BITS;
        if (rounded > TERM_MAX)
        begin
            result = TERM_MAX[DIV_BITS-1:0];
        end
        else if (rounded < TERM_MIN)
        begin
            result = TERM_MIN[DIV_BITS-1:0];
        end
        else
        begin
            result = rounded[DIV_BITS-1:0];
        end
        return result;
    endfunction

    function automatic logic signed [DIV_BITS-1:0] sat_sum(
        input logic signed [SUM_BITS-1:0] value
    );
        logic signed [DIV_BITS-1:0] result;
        if (value > SUM_MAX)
        begin
            result = SUM_MAX[DIV_BITS-1:0];
        end
        else if (value < SUM_MIN)
        begin
            result = SUM_MIN[DIV_BITS-1:0];
        end
        else
        begin
            result = value[DIV_BITS-1:0];
        end
        return result;
    endfunction

    function automatic logic signed [SUM_BITS-1:0] widen(
        input logic signed [DIV_BITS-1:0] value
    );
        logic signed [SUM_BITS-1:0] result;
        result = value;
        return result;
    endfunction

endpackage

`default_nettype wire

>>> hdl/agd_pixel_if.sv
// Input channel: one pixel item with valid/ready handshake.
`default_nettype none

interface agd_pixel_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [agd_pkg::LUMA_BITS-1:0]  log_luminance;
    logic [agd_pkg::ATTEN_BITS-1:0]        attenuation;

    modport source (output valid, output log_luminance, output attenuation, input ready);
    modport sink   (input valid, input log_luminance, input attenuation, output ready);
endinterface

`default_nettype wire

>>> hdl/agd_result_if.sv
// Output channel: one divergence result item with valid/ready handshake.
`default_nettype none

interface agd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [agd_pkg::DIV_BITS-1:0]  divergence;
    logic                                 last_of_run;
    logic                                 frame_end;

    modport source (output valid, output divergence, output last_of_run, output frame_end,
                    input ready);
    modport sink   (input valid, input divergence, input last_of_run, input frame_end,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/agd_queue.sv
// Short FIFO of classified pixel items between the front and the back.
`default_nettype none

module agd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  agd_pkg::work_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output agd_pkg::work_t  out_data
);

    localparam int PTR_BITS = (agd_pkg::QUEUE_DEPTH > 1) ? $clog2(agd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(agd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(agd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_PTR   = PTR_BITS'(agd_pkg::QUEUE_DEPTH - 1);

    agd_pkg::work_t      entry_reg [agd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != FULL_COUNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> out_valid)
        else $error("pushed item not visible at queue head");
`endif

endmodule

`default_nettype wire

>>> hdl/agd_front.sv
// Front end: frame counters, luminance/attenuation line buffer, item classification.
`default_nettype none

module agd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    agd_pixel_if.sink                           pixel,
    input  logic                                cfg_we,
    input  agd_pkg::cfg_reg_t                   cfg_index,
    input  logic [agd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                fq_valid,
    input  logic                                fq_ready,
    output agd_pkg::work_t                      fq_data
);

    localparam int CB = agd_pkg::COL_BITS;
    localparam int RB = agd_pkg::ROW_BITS;
    localparam int KB = agd_pkg::CFG_COLS_BITS;
    localparam int DB = agd_pkg::DIFF_BITS;

    typedef struct packed {
        logic signed [agd_pkg::LUMA_BITS-1:0] luma;
        logic [agd_pkg::ATTEN_BITS-1:0]       atten;
    } line_t;

    typedef struct packed {
        logic signed [agd_pkg::LUMA_BITS-1:0] luma;
        line_t                                up;
        line_t                                left;
        logic                                 use_right;
        logic [CB-1:0]                        col;
        agd_pkg::flags_t                      flags;
    } stage_t;

    line_t            line_mem [agd_pkg::MAX_COLUMNS];
    line_t            rd_reg;
    line_t            row0_reg;
    line_t            left_reg;
    line_t            cur_line;

    logic [RB-1:0]    rows_cfg_reg;
    logic [KB-1:0]    cols_cfg_reg;
    logic [RB-1:0]    rows_eff;
    logic [KB-1:0]    cols_eff;

    logic [RB-1:0]    row_reg;
    logic [RB-1:0]    row_next;
    logic [CB-1:0]    col_reg;
    logic [CB-1:0]    col_next;
    logic [RB-1:0]    cur_r;
    logic [CB-1:0]    cur_c;
    logic             restart;
    logic [KB-1:0]    col_inc;
    logic [RB:0]      row_inc;
    logic [CB-1:0]    right_addr;
    logic             last_row;
    logic             accept;

    logic             f1_valid_reg;
    logic             f1_valid_next;
    stage_t           f1_reg;
    stage_t           f1_next;

    assign rows_eff = (rows_cfg_reg < agd_pkg::MIN_ROWS) ? agd_pkg::MIN_ROWS : rows_cfg_reg;
    assign cols_eff = (cols_cfg_reg < agd_pkg::MIN_COLS) ? agd_pkg::MIN_COLS :
                      (cols_cfg_reg > agd_pkg::MAX_COLS) ? agd_pkg::MAX_COLS : cols_cfg_reg;

    // Restart the frame when a size change leaves the counters outside it.
    assign restart = ({1'b0, col_reg} >= cols_eff) || (row_reg >= rows_eff);
    assign cur_c   = restart ? '0 : col_reg;
    assign cur_r   = restart ? '0 : row_reg;
    assign col_inc = {1'b0, cur_c} + KB'(1);
    assign row_inc = {1'b0, cur_r} + (RB + 1)'(1);
    assign right_addr = cur_c + CB'(1);
    assign last_row = (cur_r == rows_eff - RB'(1));

    assign pixel.ready = !f1_valid_reg || fq_ready;
    assign accept      = pixel.valid && pixel.ready;
    assign cur_line    = '{luma: pixel.log_luminance, atten: pixel.attenuation};

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_inc >= cols_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[RB-1:0];
            end
            else
            begin
                col_next = col_inc[CB-1:0];
                row_next = cur_r;
            end
        end
    end

    always_comb
    begin
        f1_next.luma            = pixel.log_luminance;
        // Column 0 has no previous read to reuse; take its row copy instead.
        f1_next.up              = (cur_c == '0) ? row0_reg : rd_reg;
        f1_next.left            = left_reg;
        f1_next.use_right       = (col_inc < cols_eff);
        f1_next.col             = cur_c;
        f1_next.flags.sub_left  = (cur_c != '0);
        f1_next.flags.sub_above = (cur_r >= RB'(2));
        f1_next.flags.last_left = last_row && (cur_c != '0);
        f1_next.flags.sub_lrh   = (cur_c >= CB'(2));
        f1_next.flags.last_col  = last_row && (col_inc == cols_eff);
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
        begin
            // Row 0 causes no result, since it is never the last row; drop it here.
            f1_valid_next = (cur_r != '0);
        end
        else if (fq_ready)
        begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= agd_pkg::MIN_ROWS;
            cols_cfg_reg <= agd_pkg::MIN_COLS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                agd_pkg::REG_IMAGE_ROWS:    rows_cfg_reg <= cfg_data[RB-1:0];
                agd_pkg::REG_IMAGE_COLUMNS: cols_cfg_reg <= cfg_data[KB-1:0];
                default:                    rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            left_reg     <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            f1_valid_reg <= f1_valid_next;
            if (accept)
            begin
                left_reg <= cur_line;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_reg <= f1_next;
            if (cur_c == '0)
            begin
                row0_reg <= cur_line;
            end
        end
    end

    // Line buffer: write this pixel, fetch the one to the right from the row above.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[cur_c] <= cur_line;
            rd_reg          <= line_mem[right_addr];
        end
    end

    assign fq_valid = f1_valid_reg;

    always_comb
    begin
        fq_data.diff_right = f1_reg.use_right ?
            ($signed({rd_reg.luma[agd_pkg::LUMA_BITS-1], rd_reg.luma})
             - $signed({f1_reg.up.luma[agd_pkg::LUMA_BITS-1], f1_reg.up.luma})) : DB'(0);
        fq_data.diff_below =
            $signed({f1_reg.luma[agd_pkg::LUMA_BITS-1], f1_reg.luma})
            - $signed({f1_reg.up.luma[agd_pkg::LUMA_BITS-1], f1_reg.up.luma});
        fq_data.diff_left =
            $signed({f1_reg.luma[agd_pkg::LUMA_BITS-1], f1_reg.luma})
            - $signed({f1_reg.left.luma[agd_pkg::LUMA_BITS-1], f1_reg.left.luma});
        fq_data.up_atten   = f1_reg.up.atten;
        fq_data.left_atten = f1_reg.left.atten;
        fq_data.col        = f1_reg.col;
        fq_data.flags      = f1_reg.flags;
    end

`ifndef ASSERT_OFF
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        f1_valid_reg && !fq_ready |=> f1_valid_reg && $stable(fq_data))
        else $error("front stage item changed while the queue was full");
`endif

endmodule

`default_nettype wire

>>> hdl/agd_back.sv
// Back end: attenuated gradient terms, vertical-term line buffer, result sequencing.
`default_nettype none

module agd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            qb_valid,
    output logic            qb_ready,
    input  agd_pkg::work_t  qb_data,
    agd_result_if.source    result
);

    localparam int DB = agd_pkg::DIV_BITS;
    localparam int SB = agd_pkg::SUM_BITS;
    localparam logic signed [SB-1:0] SUM_ZERO = '0;

    typedef struct packed {
        logic signed [DB-1:0] horiz;
        logic signed [DB-1:0] vert;
        logic signed [DB-1:0] left_horiz;
        logic signed [DB-1:0] vert_above;
        agd_pkg::flags_t      flags;
    } term_t;

    typedef enum logic [2:0] {
        PH_VERT   = 3'b001,
        PH_LEFT   = 3'b010,
        PH_CORNER = 3'b100
    } phase_t;

    logic signed [DB-1:0] vert_mem [agd_pkg::MAX_COLUMNS];
    logic signed [DB-1:0] vrd_reg;

    logic                 b1_valid_reg;
    logic                 b1_valid_next;
    agd_pkg::work_t       b1_reg;
    logic                 b1_adv;
    logic                 pop;
    logic signed [DB-1:0] horiz_w;
    logic signed [DB-1:0] vert_w;
    logic signed [DB-1:0] left_horiz_w;

    logic                 b2_valid_reg;
    logic                 b2_valid_next;
    term_t                b2_reg;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic                 final_w;
    logic                 b2_done;

    logic signed [DB-1:0] prev_h_reg;
    logic signed [DB-1:0] prev_v_reg;
    logic signed [DB-1:0] lrh_reg;

    logic signed [SB-1:0] sum_vert;
    logic signed [SB-1:0] sum_left;
    logic signed [SB-1:0] sum_corner;
    logic signed [SB-1:0] sum_sel;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [DB-1:0] out_div_reg;
    logic                 out_last_reg;
    logic                 out_fend_reg;
    logic                 out_load;

    assign b1_adv   = b1_valid_reg && (!b2_valid_reg || b2_done);
    assign qb_ready = !b1_valid_reg || b1_adv;
    assign pop      = qb_valid && qb_ready;

    assign horiz_w      = agd_pkg::scaled_term(b1_reg.up_atten, b1_reg.diff_right);
    assign vert_w       = agd_pkg::scaled_term(b1_reg.up_atten, b1_reg.diff_below);
    assign left_horiz_w = agd_pkg::scaled_term(b1_reg.left_atten, b1_reg.diff_left);

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (pop)
        begin
            b1_valid_next = 1'b1;
        end
        else if (b1_adv)
        begin
            b1_valid_next = 1'b0;
        end
    end

    // Vertical-term line: read the row above on pop, write this row's term on advance.
    always_ff @(posedge clk)
    begin
        if (b1_adv)
        begin
            vert_mem[b1_reg.col] <= vert_w;
        end
        if (pop)
        begin
            vrd_reg <= vert_mem[qb_data.col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_reg <= qb_data;
        end
        if (b1_adv)
        begin
            b2_reg.horiz      <= horiz_w;
            b2_reg.vert       <= vert_w;
            b2_reg.left_horiz <= left_horiz_w;
            b2_reg.vert_above <= vrd_reg;
            b2_reg.flags      <= b1_reg.flags;
        end
    end

    always_comb
    begin
        sum_vert = agd_pkg::widen(b2_reg.horiz) + agd_pkg::widen(b2_reg.vert)
                 - (b2_reg.flags.sub_left  ? agd_pkg::widen(prev_h_reg)        : SUM_ZERO)
                 - (b2_reg.flags.sub_above ? agd_pkg::widen(b2_reg.vert_above) : SUM_ZERO);
        sum_left = agd_pkg::widen(b2_reg.left_horiz) - agd_pkg::widen(prev_v_reg)
                 - (b2_reg.flags.sub_lrh ? agd_pkg::widen(lrh_reg) : SUM_ZERO);
        // Bottom-right pixel: no right or lower neighbor, only the incoming terms.
        sum_corner = SUM_ZERO - agd_pkg::widen(b2_reg.left_horiz)
                   - agd_pkg::widen(b2_reg.vert);
    end

    always_comb
    begin
        sum_sel    = sum_vert;
        final_w    = 1'b1;
        phase_next = phase_reg;
        case (phase_reg)
            PH_VERT:
            begin
                sum_sel = sum_vert;
                final_w = !b2_reg.flags.last_left && !b2_reg.flags.last_col;
                if (b2_reg.flags.last_left)
                begin
                    phase_next = PH_LEFT;
                end
                else
                begin
                    phase_next = PH_CORNER;
                end
            end
            PH_LEFT:
            begin
                sum_sel    = sum_left;
                final_w    = !b2_reg.flags.last_col;
                phase_next = PH_CORNER;
            end
            PH_CORNER:
            begin
                sum_sel    = sum_corner;
                final_w    = 1'b1;
                phase_next = PH_VERT;
            end
            default:
            begin
                sum_sel    = sum_vert;
                final_w    = 1'b1;
                phase_next = PH_VERT;
            end
        endcase
        if (final_w)
        begin
            phase_next = PH_VERT;
        end
    end

    assign out_load = b2_valid_reg && (!out_valid_reg || result.ready);
    assign b2_done  = out_load && final_w;

    always_comb
    begin
        b2_valid_next = b2_valid_reg;
        if (b1_adv)
        begin
            b2_valid_next = 1'b1;
        end
        else if (b2_done)
        begin
            b2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_VERT;
            prev_h_reg    <= '0;
            prev_v_reg    <= '0;
            lrh_reg       <= '0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                phase_reg <= phase_next;
            end
            // Advance the running neighbor terms once the item is fully emitted.
            if (b2_done)
            begin
                prev_h_reg <= b2_reg.horiz;
                prev_v_reg <= b2_reg.vert;
                if (b2_reg.flags.last_left)
                begin
                    lrh_reg <= b2_reg.left_horiz;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_div_reg  <= agd_pkg::sat_sum(sum_sel);
            out_last_reg <= final_w;
            out_fend_reg <= (phase_reg == PH_CORNER);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.divergence  = out_div_reg;
    assign result.last_of_run = out_last_reg;
    assign result.frame_end   = out_fend_reg;

`ifndef ASSERT_OFF
    a_fend_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fend_reg |-> out_last_reg)
        else $error("frame end result is not the last of its run");

    a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_VERT |-> b2_valid_reg)
        else $error("result sequencer past first result with no item");

    a_b2_leaves_via_output: assert property (@(posedge clk) disable iff (!rst_n)
        b2_valid_reg && !out_load |=> b2_valid_reg && $stable(b2_reg))
        else $error("term stage changed before its results were emitted");
`endif

endmodule

`default_nettype wire

>>> hdl/attenuated_gradient_divergence_core.sv
// Top level of the attenuated gradient divergence block.
`default_nettype none

// Takes pixels in raster order (log luminance Q5.10, attenuation Q4.12) and returns
// for every pixel the divergence of its attenuated forward gradients, Q13.10 saturated.
// Results lag one row: row 0 gives none, each pixel of a later row gives the result of
// the pixel above it, one per clock unless the receiver stalls. On the last row each
// pixel from column 1 on also gives the result of its left neighbor, and the frame's
// final pixel adds its own, so there the single result port sets the pace.
// Elsewhere the block takes one pixel per clock while the receiver keeps up. A front
// stage counts rows and columns and reads the luminance line buffer; a four-entry
// queue decouples it from the back, which multiplies, keeps the vertical-term line
// buffer and sequences the results.
// Line buffers hold 4096 columns; their contents are meaningful only once written.
module attenuated_gradient_divergence_core (
    input  logic                               clk,
    input  logic                               rst_n,
    agd_pixel_if.sink                          pixel,
    agd_result_if.source                       result,
    input  logic                               cfg_we,
    input  agd_pkg::cfg_reg_t                  cfg_index,
    input  logic [agd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic            fq_valid;
    logic            fq_ready;
    agd_pkg::work_t  fq_data;
    logic            qb_valid;
    logic            qb_ready;
    agd_pkg::work_t  qb_data;

    agd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fq_valid  (fq_valid),
        .fq_ready  (fq_ready),
        .fq_data   (fq_data)
    );

    agd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    agd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qb_valid (qb_valid),
        .qb_ready (qb_ready),
        .qb_data  (qb_data),
        .result   (result)
    );

endmodule

`default_nettype wire

>>> dv/agd_divergence_tracker.sv
// Predicts the divergence results of each accepted pixel and compares them with the block.
module agd_divergence_tracker
    import agd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    agd_pixel_if                      pixel,
    agd_result_if                     result,
    input  logic                      cfg_we,
    input  cfg_reg_t                  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        failures,
    output int                        pending
);

    localparam longint DIV_HI = (longint'(1) << (DIV_BITS - 1)) - 1;
    localparam longint DIV_LO = -(longint'(1) << (DIV_BITS - 1));

    typedef struct packed {
        logic signed [DIV_BITS-1:0] divergence;
        logic                       last_of_run;
        logic                       frame_end;
    } div_result_t;

    div_result_t pending_divergence[$];

    logic [ROW_BITS-1:0]      rows_reg;
    logic [CFG_COLS_BITS-1:0] cols_reg;

    longint                luma_row [MAX_COLUMNS];
    logic [ATTEN_BITS-1:0] atten_row [MAX_COLUMNS];
    longint                vterm_row [MAX_COLUMNS];

    longint                horiz_prev;
    longint                last_row_horiz;
    longint                prev_luma;
    logic [ATTEN_BITS-1:0] prev_atten;
    int unsigned           row_pos;
    int unsigned           col_pos;

    function automatic longint clamp24(input longint v);
        if (v > DIV_HI)
        begin
            return DIV_HI;
        end
        if (v < DIV_LO)
        begin
            return DIV_LO;
        end
        return v;
    endfunction

    // Exact product, rounded to Q.10 with ties up; the arithmetic shift floors.
    function automatic longint gradient_term(input logic [ATTEN_BITS-1:0] atten,
                                             input longint diff);
        longint a;
        longint q;
        a = atten;
        q = a * diff + (longint'(1) << (ATTEN_FRAC_BITS - 1));
        return clamp24(q >>> ATTEN_FRAC_BITS);
    endfunction

    function automatic div_result_t make_result(input longint d, input logic fend);
        div_result_t item;
        item.divergence  = DIV_BITS'(clamp24(d));
        item.last_of_run = 1'b0;
        item.frame_end   = fend;
        return item;
    endfunction

    task automatic predict_divergence(input logic signed [LUMA_BITS-1:0] lum_in,
                                      input logic [ATTEN_BITS-1:0] att);
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned r;
        int unsigned c;
        longint      lum;
        longint      lu;
        longint      h;
        longint      v;
        longint      h2;
        longint      d;
        logic [ATTEN_BITS-1:0] au;
        div_result_t batch [3];
        int          n;

        rows_eff = (rows_reg < 2) ? 2 : rows_reg;
        cols_eff = (cols_reg < 2) ? 2 : cols_reg;
        if (cols_eff > MAX_COLUMNS)
        begin
            cols_eff = MAX_COLUMNS;
        end
        // restart the frame when a size change left the counters outside it
        if (col_pos >= cols_eff || row_pos >= rows_eff)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        r   = row_pos;
        c   = col_pos;
        lum = lum_in;
        n   = 0;

        if (r >= 1)
        begin
            lu = luma_row[c];
            au = atten_row[c];
            h  = 0;
            if (c + 1 < cols_eff)
            begin
                h = gradient_term(au, luma_row[c + 1] - lu);
            end
            v = gradient_term(au, lum - lu);
            d = h + v;
            if (c > 0)
            begin
                d = d - horiz_prev;
            end
            if (r >= 2)
            begin
                d = d - vterm_row[c];
            end
            batch[n] = make_result(d, 1'b0);
            n++;
            horiz_prev   = h;
            vterm_row[c] = v;
        end

        // last row: results for the left neighbor and, at the end, this pixel
        if (r == rows_eff - 1)
        begin
            if (c >= 1)
            begin
                h2 = gradient_term(prev_atten, lum - prev_luma);
                d  = h2 - vterm_row[c - 1];
                if (c >= 2)
                begin
                    d = d - last_row_horiz;
                end
                batch[n] = make_result(d, 1'b0);
                n++;
                last_row_horiz = h2;
            end
            if (c == cols_eff - 1)
            begin
                batch[n] = make_result(-last_row_horiz - vterm_row[c], 1'b1);
                n++;
            end
        end

        luma_row[c]  = lum;
        atten_row[c] = att;
        prev_luma    = lum;
        prev_atten   = att;

        if (n > 0)
        begin
            batch[n - 1].last_of_run = 1'b1;
        end
        for (int k = 0; k < n; k++)
        begin
            pending_divergence = {pending_divergence, batch[k]};
        end

        c++;
        if (c >= cols_eff)
        begin
            c = 0;
            r++;
            if (r >= rows_eff)
            begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic report_mismatch(input string msg);
        failures++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_result();
        div_result_t want;
        if (pending_divergence.size() == 0)
        begin
            report_mismatch($sformatf("result with none predicted: divergence %0d",
                                      result.divergence));
        end
        else
        begin
            want = pending_divergence.pop_front();
            if (result.divergence !== want.divergence)
            begin
                report_mismatch($sformatf("divergence: got %0d want %0d",
                                          result.divergence, want.divergence));
            end
            if (result.last_of_run !== want.last_of_run)
            begin
                report_mismatch($sformatf("last_of_run: got %b want %b",
                                          result.last_of_run, want.last_of_run));
            end
            if (result.frame_end !== want.frame_end)
            begin
                report_mismatch($sformatf("frame_end: got %b want %b",
                                          result.frame_end, want.frame_end));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg       = ROW_BITS'(2);
            cols_reg       = CFG_COLS_BITS'(2);
            horiz_prev     = 0;
            last_row_horiz = 0;
            prev_luma      = 0;
            prev_atten     = '0;
            row_pos        = 0;
            col_pos        = 0;
            failures       = 0;
            pending_divergence.delete();
            pending        = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_ROWS)
                begin
                    rows_reg = cfg_data[ROW_BITS-1:0];
                end
                else
                begin
                    cols_reg = cfg_data[CFG_COLS_BITS-1:0];
                end
            end
            if (pixel.valid && pixel.ready)
            begin
                predict_divergence(pixel.log_luminance, pixel.attenuation);
            end
            if (result.valid && result.ready)
            begin
                check_result();
            end
            pending = pending_divergence.size();
        end
    end

endmodule

>>> dv/attenuated_gradient_divergence_core_tb.sv
// Stimulus and verdict for the attenuated gradient divergence block.
module attenuated_gradient_divergence_core_tb;
    import agd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 170;

    localparam logic signed [LUMA_BITS-1:0] TIE_LUMA [9] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd2, 16'sd3, 16'sd2
    };
    localparam logic [ATTEN_BITS-1:0] TIE_ATTEN [9] = '{
        16'd2048, 16'd2048, 16'd6144, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'h1000, 16'd2048
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    cfg_reg_t                 cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       failures;
    int                       pending;

    bit steady_source;
    bit steady_sink;
    int hold_requests;
    int idle_cycles;

    agd_pixel_if  pixel ();
    agd_result_if result ();

    attenuated_gradient_divergence_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    agd_divergence_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 2)
        begin
            return 2;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic int pick_gap();
        int pick;
        if (steady_source)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return 0;
        end
        if (pick < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 60);
    endfunction

    function automatic int unsigned pick_rows();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return $urandom_range(0, 1);
        end
        return (pick < 8) ? $urandom_range(2, 5) : $urandom_range(6, 10);
    endfunction

    function automatic int unsigned pick_cols();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return $urandom_range(0, 1);
        end
        return (pick < 8) ? $urandom_range(2, 8) : $urandom_range(9, 40);
    endfunction

    // Call on a rising edge; returns on the edge that accepts the item.
    task automatic send_pixel(input logic signed [LUMA_BITS-1:0] lum,
                              input logic [ATTEN_BITS-1:0] att);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel.valid         <= 1'b1;
        pixel.log_luminance <= lum;
        pixel.attenuation   <= att;
        @(posedge clk);
        while (!pixel.ready) @(posedge clk);
    endtask

    task automatic send_frame(input int unsigned pixels);
        logic signed [LUMA_BITS-1:0] lum;
        logic [ATTEN_BITS-1:0]       att;
        int                          style;
        int                          pick;
        style = $urandom_range(0, 3);
        lum   = LUMA_BITS'($urandom);
        for (int unsigned k = 0; k < pixels; k++)
        begin
            case (style)
                1:       lum = lum + LUMA_BITS'($urandom_range(0, 64)) - 16'sd32;
                2:       lum = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: lum = LUMA_BITS'($urandom);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       att = '0;
                1:       att = '1;
                2:       att = 16'h1000;
                3:       att = 16'h0800;
                default: att = ATTEN_BITS'($urandom);
            endcase
            send_pixel(lum, att);
        end
    endtask

    // Drop valid and wait until every predicted result is out, plus the pipeline depth.
    task automatic settle();
        pixel.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned rows, input int unsigned cols);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_ROWS;
        cfg_data  <= CFG_DATA_BITS'(rows);
        @(posedge clk);
        cfg_index <= REG_IMAGE_COLUMNS;
        cfg_data  <= CFG_DATA_BITS'(cols);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, steady stretches and the long hold on request.
    initial
    begin
        int stall;
        int served;
        int pick;
        result.ready = 1'b0;
        stall  = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                stall  = LONG_HOLD;
            end
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                stall--;
            end
            else if (steady_sink)
            begin
                result.ready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    result.ready <= 1'b1;
                end
                else
                begin
                    result.ready <= 1'b0;
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                    begin
                        stall = $urandom_range(0, 2);
                    end
                    else if (pick < 97)
                    begin
                        stall = $urandom_range(3, 10);
                    end
                    else
                    begin
                        stall = $urandom_range(20, 60);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel.valid && pixel.ready) || (result.valid && result.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned rows_w;
        int unsigned cols_w;
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned random_items;
        int          frame_no;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_IMAGE_ROWS;
        cfg_data            = '0;
        pixel.valid         = 1'b0;
        pixel.log_luminance = '0;
        pixel.attenuation   = '0;
        steady_source       = 1'b0;
        steady_sink         = 1'b0;
        hold_requests       = 0;
        idle_cycles         = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 2x2: field extremes, the second row is already the last
        send_pixel(16'sh7FFF, 16'hFFFF);
        send_pixel(16'sh8000, 16'hFFFF);
        send_pixel(16'sh8000, 16'h0000);
        send_pixel(16'sh7FFF, 16'h0800);

        // 3x3 with rounding ties and full-scale differences
        settle();
        set_frame(3, 3);
        for (int k = 0; k < 9; k++)
        begin
            send_pixel(TIE_LUMA[k], TIE_ATTEN[k]);
        end

        // sizes below the minimum act as 2x2
        settle();
        set_frame(0, 1);
        send_frame(4);

        // tallest frame, cut short: shrinking rows past the row counter restarts it
        settle();
        set_frame(16'hFFFF, 3);
        send_frame(7);
        settle();
        set_frame(1, 3);
        send_frame(6);

        // column register beyond the line buffer: start a row, then a smaller size
        // leaves the column counter outside the frame and restarts it
        settle();
        set_frame(2, 8191);
        send_frame(6);
        settle();
        set_frame(2, 2);
        send_frame(4);

        random_items = 0;
        frame_no     = 0;
        rows_eff     = 2;
        cols_eff     = 2;
        while (random_items < RANDOM_ITEMS)
        begin
            if (frame_no % 5 == 0)
            begin
                // hold the receiver while pixels keep coming so the block backs up
                settle();
                set_frame(4, 8);
                rows_eff      = 4;
                cols_eff      = 8;
                steady_source = 1'b1;
                steady_sink   = 1'b0;
                hold_requests++;
            end
            else
            begin
                steady_source = ($urandom_range(0, 3) == 0);
                steady_sink   = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) != 0)
                begin
                    rows_w = pick_rows();
                    cols_w = pick_cols();
                    settle();
                    set_frame(rows_w, cols_w);
                    rows_eff = clamp_size(rows_w, 65535);
                    cols_eff = clamp_size(cols_w, MAX_COLUMNS);
                end
            end
            send_frame(rows_eff * cols_eff);
            random_items += rows_eff * cols_eff;
            frame_no++;
        end

        steady_source = 1'b0;
        settle();
        if (failures == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/agd_pkg.sv
hdl/agd_pixel_if.sv
hdl/agd_result_if.sv
hdl/agd_queue.sv
hdl/agd_front.sv
hdl/agd_back.sv
hdl/attenuated_gradient_divergence_core.sv
dv/agd_divergence_tracker.sv
dv/attenuated_gradient_divergence_core_tb.sv
